>>> src/pvp_pkg.sv
package pvp_pkg;

  // field widths
  localparam int W_TRIG  = 16;
  localparam int W_DIST  = 15;
  localparam int W_SCALE = 12;
  localparam int W_CTR   = 11;
  localparam int W_WORLD = 16;
  localparam int W_SCR   = 16;
  localparam int W_CFGD  = 16;
  localparam int W_CFGI  = 3;

  // datapath widths
  localparam int W_CP = 2 * W_TRIG;           // trig * trig
  localparam int W_M  = W_CP + W_WORLD;       // trig * trig * coord
  localparam int W_E  = 48;                   // eye coordinates, Q40
  localparam int W_P  = W_E + W_SCALE + 1;    // scale * eye coord
  localparam int W_B  = W_E + W_CTR + 1;      // centre * depth
  localparam int W_N  = 64;                   // numerator
  localparam int W_R  = W_N + 1;              // partial remainder
  localparam int Q_W  = 18;                   // quotient bits, saturated to the screen range on output

  localparam int EX_SHIFT = 14;               // Q6.26 -> Q40 for single-trig terms
  localparam int ED_SHIFT = 28;               // Q3.12 -> Q40

  // reset values
  localparam logic signed [W_TRIG-1:0] TRIG_RST  = W_TRIG'(11585);
  localparam logic signed [W_CP-1:0]   CP_RST    = W_CP'(11585 * 11585);
  localparam logic [W_DIST-1:0]        DIST_RST  = W_DIST'(28378);
  localparam logic [W_SCALE-1:0]       SCALE_RST = W_SCALE'(320);
  localparam logic [W_CTR-1:0]         CX_RST    = W_CTR'(160);
  localparam logic [W_CTR-1:0]         CY_RST    = W_CTR'(120);

  localparam int SCR_MAX_I = 2 ** (W_SCR - 1) - 1;
  localparam logic signed [W_SCR-1:0] SCR_MAX = W_SCR'(SCR_MAX_I);
  localparam logic signed [W_SCR-1:0] SCR_MIN = W_SCR'(-SCR_MAX_I - 1);

  typedef enum logic [W_CFGI-1:0] {
    REG_COS_THETA,
    REG_SIN_THETA,
    REG_COS_PHI,
    REG_SIN_PHI,
    REG_EYE_DISTANCE,
    REG_SCREEN_SCALE,
    REG_CTR_X,
    REG_CTR_Y
  } cfg_reg_t;

  typedef enum logic {
    OP_CUBE,
    OP_DETECT
  } opcode_t;

  // side info carried alongside the divider
  typedef struct packed {
    logic detect;
    logic fault;
    logic x_pos;
    logic x_neg;
    logic y_pos;
    logic y_neg;
  } pvp_tag_t;

  function automatic logic signed [W_SCR-1:0] sat_quot(input logic [Q_W-1:0] q,
                                                       input logic neg);
    logic signed [W_SCR-1:0] res;
    if (neg) begin
      res = (q > Q_W'(SCR_MAX_I + 1)) ? SCR_MIN : -$signed(q[W_SCR-1:0]);
    end else begin
      res = (q > Q_W'(SCR_MAX_I)) ? SCR_MAX : $signed(q[W_SCR-1:0]);
    end
    return res;
  endfunction

endpackage

>>> src/pvp_if.sv
interface pvp_in_if import pvp_pkg::*; ();
  logic                      valid;
  logic                      ready;
  logic signed [W_WORLD-1:0] world_x;
  logic signed [W_WORLD-1:0] world_y;
  logic signed [W_WORLD-1:0] world_z;
  logic                      opcode;

  modport source(output valid, output world_x, output world_y, output world_z,
                 output opcode, input ready);
  modport sink(input valid, input world_x, input world_y, input world_z,
               input opcode, output ready);
endinterface

interface pvp_out_if import pvp_pkg::*; ();
  logic                    valid;
  logic                    ready;
  logic signed [W_SCR-1:0] screen_x;
  logic signed [W_SCR-1:0] screen_y;
  logic                    in_frame;
  logic                    depth_fault;

  modport source(output valid, output screen_x, output screen_y, output in_frame,
                 output depth_fault, input ready);
  modport sink(input valid, input screen_x, input screen_y, input in_frame,
               input depth_fault, output ready);
endinterface

>>> src/perspective_view_projector_core.sv
// Projects one Q4.12 world point per cycle onto the screen. Words pass through a
// 24-stage pipeline: trig products, eye-coordinate sums, scaling by screen_scale,
// numerator assembly, magnitude conversion, an 18-stage restoring divider (one
// quotient bit per stage, shared divisor for x and y) and the output register; one
// result leaves per cycle while out_ch.ready stays high. When the output word is
// not taken the whole pipeline holds. Configuration writes take effect at the next
// clock edge and must be made only while the pipeline is empty.
module perspective_view_projector_core import pvp_pkg::*; (
  input  logic              clk,
  input  logic              rst_n,
  pvp_in_if.sink            in_ch,
  pvp_out_if.source         out_ch,
  input  logic              cfg_we,
  input  logic [W_CFGI-1:0] cfg_index,
  input  logic [W_CFGD-1:0] cfg_wdata
);

  // configuration
  logic signed [W_TRIG-1:0] cos_theta_r, sin_theta_r, cos_phi_r, sin_phi_r;
  logic [W_DIST-1:0]        eye_distance_r;
  logic [W_SCALE-1:0]       screen_scale_r;
  logic [W_CTR-1:0]         ctr_x_r, ctr_y_r;
  // trig pair products, kept in step with the trig registers
  logic signed [W_CP-1:0]   cpct_r, cpst_r, spct_r, spst_r;
  logic signed [W_TRIG-1:0] wd;

  assign wd = $signed(cfg_wdata);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cos_theta_r    <= TRIG_RST;
      sin_theta_r    <= TRIG_RST;
      cos_phi_r      <= TRIG_RST;
      sin_phi_r      <= TRIG_RST;
      eye_distance_r <= DIST_RST;
      screen_scale_r <= SCALE_RST;
      ctr_x_r        <= CX_RST;
      ctr_y_r        <= CY_RST;
      cpct_r         <= CP_RST;
      cpst_r         <= CP_RST;
      spct_r         <= CP_RST;
      spst_r         <= CP_RST;
    end else if (cfg_we) begin
      case (cfg_reg_t'(cfg_index))
        REG_COS_THETA: begin
          cos_theta_r <= wd;
          cpct_r      <= cos_phi_r * wd;
          spct_r      <= sin_phi_r * wd;
        end
        REG_SIN_THETA: begin
          sin_theta_r <= wd;
          cpst_r      <= cos_phi_r * wd;
          spst_r      <= sin_phi_r * wd;
        end
        REG_COS_PHI: begin
          cos_phi_r <= wd;
          cpct_r    <= wd * cos_theta_r;
          cpst_r    <= wd * sin_theta_r;
        end
        REG_SIN_PHI: begin
          sin_phi_r <= wd;
          spct_r    <= wd * cos_theta_r;
          spst_r    <= wd * sin_theta_r;
        end
        REG_EYE_DISTANCE: eye_distance_r <= cfg_wdata[W_DIST-1:0];
        REG_SCREEN_SCALE: screen_scale_r <= cfg_wdata[W_SCALE-1:0];
        REG_CTR_X:        ctr_x_r        <= cfg_wdata[W_CTR-1:0];
        REG_CTR_Y:        ctr_y_r        <= cfg_wdata[W_CTR-1:0];
        default: ;
      endcase
    end
  end

  // pipeline advance
  logic en;
  logic out_valid_r;

  assign en          = !out_valid_r || out_ch.ready;
  assign in_ch.ready = en;

  // stage A: products
  logic                     va_r, det_a_r;
  logic signed [W_CP-1:0]   m1_r, m2_r, m5_r, m8_r;
  logic signed [W_M-1:0]    m3_r, m4_r, m6_r, m7_r;

  always_ff @(posedge clk) begin
    if (en) begin
      det_a_r <= (in_ch.opcode == OP_DETECT);
      m1_r    <= sin_theta_r * in_ch.world_x;
      m2_r    <= cos_theta_r * in_ch.world_y;
      m3_r    <= cpct_r * in_ch.world_x;
      m4_r    <= cpst_r * in_ch.world_y;
      m5_r    <= sin_phi_r * in_ch.world_z;
      m6_r    <= spct_r * in_ch.world_x;
      m7_r    <= spst_r * in_ch.world_y;
      m8_r    <= cos_phi_r * in_ch.world_z;
    end
  end

  // stage B: eye coordinates in Q40
  logic                  vb_r, det_b_r;
  logic signed [W_E-1:0] ex_b_r, ey_b_r, ez_b_r;
  logic signed [W_E-1:0] ex_nxt, ey_nxt, ez_nxt;

  always_comb begin
    ex_nxt = (W_E'(m2_r) - W_E'(m1_r)) <<< EX_SHIFT;
    ey_nxt = -W_E'(m3_r) - W_E'(m4_r) + (W_E'(m5_r) <<< EX_SHIFT);
    ez_nxt = W_E'(m6_r) + W_E'(m7_r) + (W_E'(m8_r) <<< EX_SHIFT)
             - $signed(W_E'(eye_distance_r) << ED_SHIFT);
  end

  always_ff @(posedge clk) begin
    if (en) begin
      det_b_r <= det_a_r;
      ex_b_r  <= ex_nxt;
      ey_b_r  <= ey_nxt;
      ez_b_r  <= ez_nxt;
    end
  end

  // stage C: scale and centre products
  logic                  vc_r, det_c_r;
  logic signed [W_P-1:0] px_c_r, py_c_r;
  logic signed [W_B-1:0] bx_c_r, by_c_r;
  logic signed [W_E-1:0] ez_c_r;

  always_ff @(posedge clk) begin
    if (en) begin
      det_c_r <= det_b_r;
      px_c_r  <= $signed({1'b0, screen_scale_r}) * ex_b_r;
      py_c_r  <= $signed({1'b0, screen_scale_r}) * ey_b_r;
      bx_c_r  <= det_b_r ? $signed({1'b0, ctr_x_r}) * ez_b_r : W_B'(0);
      by_c_r  <= det_b_r ? $signed({1'b0, ctr_y_r}) * ez_b_r : W_B'(0);
      ez_c_r  <= ez_b_r;
    end
  end

  // stage D: numerators base*z + term and zero-depth flags
  logic                  vd_r;
  logic signed [W_N-1:0] nx_d_r, ny_d_r;
  logic signed [W_E-1:0] ez_d_r;
  pvp_tag_t              tag_d_r;
  logic signed [W_N-1:0] nx_nxt, ny_nxt;
  pvp_tag_t              tag_nxt;
  logic                  px_pos, px_neg, py_pos, py_neg;

  always_comb begin
    px_neg = px_c_r[W_P-1];
    px_pos = !px_neg && (px_c_r != '0);
    py_neg = py_c_r[W_P-1];
    py_pos = !py_neg && (py_c_r != '0);
    nx_nxt = W_N'(bx_c_r) - W_N'(px_c_r);
    ny_nxt = det_c_r ? W_N'(by_c_r) + W_N'(py_c_r) : -W_N'(py_c_r);
    tag_nxt.detect = det_c_r;
    tag_nxt.fault  = (ez_c_r == '0);
    // x term is -d*ex; y term is +d*ey for detect points, -d*ey for cube corners
    tag_nxt.x_pos  = px_neg;
    tag_nxt.x_neg  = px_pos;
    tag_nxt.y_pos  = det_c_r ? py_pos : py_neg;
    tag_nxt.y_neg  = det_c_r ? py_neg : py_pos;
  end

  always_ff @(posedge clk) begin
    if (en) begin
      nx_d_r  <= nx_nxt;
      ny_d_r  <= ny_nxt;
      ez_d_r  <= ez_c_r;
      tag_d_r <= tag_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      va_r <= 1'b0;
      vb_r <= 1'b0;
      vc_r <= 1'b0;
      vd_r <= 1'b0;
    end else if (en) begin
      va_r <= in_ch.valid;
      vb_r <= va_r;
      vc_r <= vb_r;
      vd_r <= vc_r;
    end
  end

  // divider
  logic           div_valid;
  logic [Q_W-1:0] div_qx, div_qy;
  logic           div_negx, div_negy;
  pvp_tag_t       div_tag;

  pvp_div u_div (
    .clk      (clk),
    .rst_n    (rst_n),
    .en       (en),
    .in_valid (vd_r),
    .num_x    (nx_d_r),
    .num_y    (ny_d_r),
    .den      (ez_d_r),
    .tag_in   (tag_d_r),
    .out_valid(div_valid),
    .q_x      (div_qx),
    .q_y      (div_qy),
    .neg_x    (div_negx),
    .neg_y    (div_negy),
    .tag_out  (div_tag)
  );

  // output stage: saturate, zero-depth override, frame test
  logic signed [W_SCR-1:0] sx_nxt, sy_nxt, base_x, base_y;
  logic                    in_frame_nxt;
  logic signed [W_SCR-1:0] sx_r, sy_r;
  logic                    in_frame_r, fault_r;

  always_comb begin
    base_x = div_tag.detect ? $signed(W_SCR'(ctr_x_r)) : '0;
    base_y = div_tag.detect ? $signed(W_SCR'(ctr_y_r)) : '0;
    if (div_tag.fault) begin
      sx_nxt = div_tag.x_pos ? SCR_MAX : (div_tag.x_neg ? SCR_MIN : base_x);
      sy_nxt = div_tag.y_pos ? SCR_MAX : (div_tag.y_neg ? SCR_MIN : base_y);
    end else begin
      sx_nxt = sat_quot(div_qx, div_negx);
      sy_nxt = sat_quot(div_qy, div_negy);
    end
    in_frame_nxt = div_tag.detect && !div_tag.fault
                   && !sx_nxt[W_SCR-1] && !sy_nxt[W_SCR-1]
                   && ($unsigned(sx_nxt) <= W_SCR'({ctr_x_r, 1'b0}))
                   && ($unsigned(sy_nxt) <= W_SCR'({ctr_y_r, 1'b0}));
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (en) begin
      out_valid_r <= div_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      sx_r       <= sx_nxt;
      sy_r       <= sy_nxt;
      in_frame_r <= in_frame_nxt;
      fault_r    <= div_tag.fault;
    end
  end

  assign out_ch.valid       = out_valid_r;
  assign out_ch.screen_x    = sx_r;
  assign out_ch.screen_y    = sy_r;
  assign out_ch.in_frame    = in_frame_r;
  assign out_ch.depth_fault = fault_r;

endmodule

>>> src/pvp_div.sv
// Two-lane restoring divider sharing one divisor, one quotient bit per stage.
module pvp_div import pvp_pkg::*; (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  en,
  input  logic                  in_valid,
  input  logic signed [W_N-1:0] num_x,
  input  logic signed [W_N-1:0] num_y,
  input  logic signed [W_E-1:0] den,
  input  pvp_tag_t              tag_in,
  output logic                  out_valid,
  output logic [Q_W-1:0]        q_x,
  output logic [Q_W-1:0]        q_y,
  output logic                  neg_x,
  output logic                  neg_y,
  output pvp_tag_t              tag_out
);

  logic           v_r    [Q_W+1];
  logic [W_R-1:0] rx_r   [Q_W];
  logic [W_R-1:0] ry_r   [Q_W];
  logic [W_E-1:0] d_r    [Q_W];
  logic [Q_W-1:0] qx_r   [1:Q_W];
  logic [Q_W-1:0] qy_r   [1:Q_W];
  logic           negx_r [Q_W+1];
  logic           negy_r [Q_W+1];
  pvp_tag_t       tag_r  [Q_W+1];

  logic [W_N-1:0] ax, ay;
  logic [W_E-1:0] ad;

  assign ax = num_x[W_N-1] ? W_N'(-num_x) : W_N'(num_x);
  assign ay = num_y[W_N-1] ? W_N'(-num_y) : W_N'(num_y);
  assign ad = den[W_E-1]   ? W_E'(-den)   : W_E'(den);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v_r[0] <= 1'b0;
    end else if (en) begin
      v_r[0] <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      rx_r[0]   <= W_R'(ax);
      ry_r[0]   <= W_R'(ay);
      d_r[0]    <= ad;
      negx_r[0] <= num_x[W_N-1] ^ den[W_E-1];
      negy_r[0] <= num_y[W_N-1] ^ den[W_E-1];
      tag_r[0]  <= tag_in;
    end
  end

  for (genvar k = 0; k < Q_W; k++) begin : g_bit
    localparam int SH = Q_W - 1 - k;

    logic [W_R-1:0] dsh;
    logic           gx, gy;
    logic [Q_W-1:0] qx_prev, qy_prev, qx_nxt, qy_nxt;

    assign dsh = W_R'(d_r[k]) << SH;
    assign gx  = rx_r[k] >= dsh;
    assign gy  = ry_r[k] >= dsh;

    if (k == 0) begin : g_first
      assign qx_prev = '0;
      assign qy_prev = '0;
    end else begin : g_rest
      assign qx_prev = qx_r[k];
      assign qy_prev = qy_r[k];
    end

    always_comb begin
      qx_nxt     = qx_prev;
      qy_nxt     = qy_prev;
      qx_nxt[SH] = gx;
      qy_nxt[SH] = gy;
    end

    always_ff @(posedge clk) begin
      if (!rst_n) begin
        v_r[k+1] <= 1'b0;
      end else if (en) begin
        v_r[k+1] <= v_r[k];
      end
    end

    always_ff @(posedge clk) begin
      if (en) begin
        qx_r[k+1]   <= qx_nxt;
        qy_r[k+1]   <= qy_nxt;
        negx_r[k+1] <= negx_r[k];
        negy_r[k+1] <= negy_r[k];
        tag_r[k+1]  <= tag_r[k];
      end
    end

    if (k < Q_W - 1) begin : g_carry
      logic [W_R-1:0] rx_nxt, ry_nxt;

      assign rx_nxt = gx ? rx_r[k] - dsh : rx_r[k];
      assign ry_nxt = gy ? ry_r[k] - dsh : ry_r[k];

      always_ff @(posedge clk) begin
        if (en) begin
          rx_r[k+1] <= rx_nxt;
          ry_r[k+1] <= ry_nxt;
          d_r[k+1]  <= d_r[k];
        end
      end
    end
  end

  assign out_valid = v_r[Q_W];
  assign q_x       = qx_r[Q_W];
  assign q_y       = qy_r[Q_W];
  assign neg_x     = negx_r[Q_W];
  assign neg_y     = negy_r[Q_W];
  assign tag_out   = tag_r[Q_W];

endmodule
